// ----- design/ogg_prc_pkg.sv -----
package ogg_prc_pkg;

   localparam int OFFSET_W = 17;
   localparam int BODY_W   = 16;
   localparam int CRC_W    = 32;
   localparam int CSR_W    = 32;

   localparam logic [OFFSET_W-1:0] SYNC_LEN   = OFFSET_W'(4);
   localparam logic [OFFSET_W-1:0] SERIAL_POS = OFFSET_W'(14);
   localparam logic [OFFSET_W-1:0] SEQ_POS    = OFFSET_W'(18);
   localparam logic [OFFSET_W-1:0] CRC_POS    = OFFSET_W'(22);
   localparam logic [OFFSET_W-1:0] SEG_POS    = OFFSET_W'(26);
   localparam logic [OFFSET_W-1:0] FIELD_LEN  = OFFSET_W'(4);

   localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;

   typedef enum logic [0:0] {
      CSR_STREAM_SERIAL  = 1'b0,
      CSR_SEQUENCE_DELTA = 1'b1
   } csr_index_type;

   // control from the header tracker to the checksum unit
   typedef struct packed {
      logic       update;
      logic       restart;
      logic [7:0] data;
   } crc_ctl_type;

   // capture pattern "OggS"
   function automatic logic [7:0] capture_byte(input logic [1:0] idx);
      logic [7:0] val;
      unique case (idx)
         2'd0: val = 8'h4F;
         2'd1: val = 8'h67;
         2'd2: val = 8'h67;
         2'd3: val = 8'h53;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ----- design/ogg_prc_req_if.sv -----
interface ogg_prc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

// ----- design/ogg_prc_rsp_if.sv -----
interface ogg_prc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        page_end;
   logic        patch_checksum;
   logic [31:0] new_checksum;
   logic        raw_mode;

   modport source (output valid, output out_byte, output page_end, output patch_checksum,
                   output new_checksum, output raw_mode, input ready);
   modport sink (input valid, input out_byte, input page_end, input patch_checksum,
                 input new_checksum, input raw_mode, output ready);
endinterface

// ----- design/ogg_page_renumber_crc.sv -----
// Ogg page renumbering with checksum recomputation.
// req_ch carries one stream byte per transaction; rsp_ch returns exactly one
// result per byte, in order: the rewritten byte, a page end flag, and at the
// end of a renumbered page the flag patch_checksum with the page's new CRC-32,
// which downstream logic writes little-endian at page offset 22.
// raw_mode rises once a page start fails the OggS check; from then on every
// byte is copied unchanged until reset.
// csr_*: write stream_serial (index 0) or sequence_delta (index 1) while idle.
// The header tracking and the byte-wide CRC update sit between the request and the
// result register. Throughput is one byte per cycle while the receiver takes each
// result; a new byte is taken in the same cycle that the held result leaves.
// When the receiver stalls, the result register holds and req_ch.ready drops
// until it is taken; no byte is dropped or repeated.
// Synchronous reset clears the page tracking, the checksum, the sync flag,
// both registers and the result valid flag; there is no clearing pass.
module ogg_page_renumber_crc (
   input  logic                                 clock,
   input  logic                                 reset,
   ogg_prc_req_if.sink                          req_ch,
   ogg_prc_rsp_if.source                        rsp_ch,
   input  logic                                 csr_write_enable,
   input  ogg_prc_pkg::csr_index_type           csr_index,
   input  logic [ogg_prc_pkg::CSR_W-1:0]        csr_write_data
);

   localparam int OW = ogg_prc_pkg::OFFSET_W;
   localparam int BW = ogg_prc_pkg::BODY_W;

   logic [31:0]        stream_serial_ff;
   logic signed [31:0] sequence_delta_ff;

   logic [OW-1:0] page_offset_ff, page_offset_in;
   logic [7:0]    segment_count_ff, segment_count_in;
   logic [BW-1:0] body_length_ff, body_length_in;
   logic          serial_match_ff, serial_match_in;
   logic          sequence_carry_ff, sequence_carry_in;
   logic          sync_lost_ff, sync_lost_in;

   logic          rsp_valid_ff;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          page_end_ff, page_end_in;
   logic          patch_ff, patch_in;
   logic [31:0]   checksum_ff, checksum_in;
   logic          raw_ff, raw_in;

   logic          accept;
   logic [OW-1:0] p;
   logic [7:0]    b;
   logic          lost;
   logic          active;
   logic [1:0]    k;
   logic [8:0]    seq_sum;
   logic [OW-1:0] end_pos;
   logic          page_last;

   ogg_prc_pkg::crc_ctl_type crc_ctl;
   logic [ogg_prc_pkg::CRC_W-1:0] crc_next;

   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   assign p = page_offset_ff;
   assign b = req_ch.in_byte;
   // the serial, sequence and checksum fields all start on offset 2 mod 4
   assign k = 2'(p[1:0] - 2'd2);

   always_comb begin
      lost   = sync_lost_ff ||
               (p < ogg_prc_pkg::SYNC_LEN && b != ogg_prc_pkg::capture_byte(p[1:0]));
      active = serial_match_ff && (sequence_delta_ff != 0);

      out_byte_in       = b;
      serial_match_in   = serial_match_ff;
      sequence_carry_in = sequence_carry_ff;
      segment_count_in  = segment_count_ff;
      body_length_in    = body_length_ff;
      seq_sum           = 9'(b) + 9'(sequence_delta_ff[8*k +: 8]) +
                          9'((p == ogg_prc_pkg::SEQ_POS) ? 1'b0 : sequence_carry_ff);

      if (p >= ogg_prc_pkg::SERIAL_POS &&
          p < ogg_prc_pkg::SERIAL_POS + ogg_prc_pkg::FIELD_LEN) begin
         if (p == ogg_prc_pkg::SERIAL_POS) begin
            serial_match_in = (stream_serial_ff[8*k +: 8] == b);
         end else begin
            serial_match_in = serial_match_ff && (stream_serial_ff[8*k +: 8] == b);
         end
      end else if (p >= ogg_prc_pkg::SEQ_POS &&
                   p < ogg_prc_pkg::SEQ_POS + ogg_prc_pkg::FIELD_LEN) begin
         sequence_carry_in = seq_sum[8];
         if (active) begin
            out_byte_in = seq_sum[7:0];
         end
      end else if (p >= ogg_prc_pkg::CRC_POS &&
                   p < ogg_prc_pkg::CRC_POS + ogg_prc_pkg::FIELD_LEN) begin
         if (active) begin
            out_byte_in = 8'h00;
         end
      end else if (p == ogg_prc_pkg::SEG_POS) begin
         segment_count_in = b;
         body_length_in   = '0;
      end else if (p > ogg_prc_pkg::SEG_POS &&
                   p <= ogg_prc_pkg::SEG_POS + OW'(segment_count_ff)) begin
         body_length_in = body_length_ff + BW'(b);
      end

      // page end uses the lengths as updated by this byte
      end_pos   = ogg_prc_pkg::SEG_POS + OW'(segment_count_in) + OW'(body_length_in);
      page_last = (p >= ogg_prc_pkg::SEG_POS) && (p == end_pos);

      crc_ctl.update  = accept && !lost;
      crc_ctl.restart = (p == '0);
      crc_ctl.data    = out_byte_in;

      if (lost) begin
         page_end_in = 1'b0;
         patch_in    = 1'b0;
         checksum_in = '0;
         raw_in      = 1'b1;
         out_byte_in = b;
      end else begin
         page_end_in = page_last;
         patch_in    = page_last && active;
         checksum_in = (page_last && active) ? crc_next : '0;
         raw_in      = 1'b0;
      end

      sync_lost_in   = lost;
      page_offset_in = page_last ? '0 : p + OW'(1);
   end

   ogg_prc_crc u_crc (
      .clock    (clock),
      .reset    (reset),
      .ctl      (crc_ctl),
      .crc_next (crc_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_serial_ff  <= '0;
         sequence_delta_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ogg_prc_pkg::CSR_STREAM_SERIAL:  stream_serial_ff  <= csr_write_data;
            ogg_prc_pkg::CSR_SEQUENCE_DELTA: sequence_delta_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_offset_ff    <= '0;
         segment_count_ff  <= '0;
         body_length_ff    <= '0;
         serial_match_ff   <= 1'b0;
         sequence_carry_ff <= 1'b0;
         sync_lost_ff      <= 1'b0;
      end else if (accept) begin
         sync_lost_ff <= sync_lost_in;
         if (!lost) begin
            page_offset_ff    <= page_offset_in;
            segment_count_ff  <= segment_count_in;
            body_length_ff    <= body_length_in;
            serial_match_ff   <= serial_match_in;
            sequence_carry_ff <= sequence_carry_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_byte_ff <= out_byte_in;
         page_end_ff <= page_end_in;
         patch_ff    <= patch_in;
         checksum_ff <= checksum_in;
         raw_ff      <= raw_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_byte       = out_byte_ff;
   assign rsp_ch.page_end       = page_end_ff;
   assign rsp_ch.patch_checksum = patch_ff;
   assign rsp_ch.new_checksum   = checksum_ff;
   assign rsp_ch.raw_mode       = raw_ff;

`ifndef SYNTH
   // once sync is lost it stays lost until reset
   a_sync_sticky: assert property (@(posedge clock) disable iff (reset)
      sync_lost_ff |=> sync_lost_ff)
      else $error("sync lost flag cleared without reset");

   // a checksum patch only ever comes with a page end in framed mode
   a_patch_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && patch_ff) |-> (page_end_ff && !raw_ff))
      else $error("checksum patch outside a page end");

   // a framed page end restarts the page offset
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && !lost && page_last) |=> (page_offset_ff == '0))
      else $error("page offset not restarted after page end");

   // zero delta leaves every byte untouched
   a_zero_delta: assert property (@(posedge clock) disable iff (reset)
      (accept && sequence_delta_ff == 0) |=> (out_byte_ff == $past(b) && !patch_ff))
      else $error("byte changed with zero delta");
`endif

endmodule

// ----- design/ogg_prc_crc.sv -----
module ogg_prc_crc (
   input  logic                            clock,
   input  logic                            reset,
   input  ogg_prc_pkg::crc_ctl_type        ctl,
   output logic [ogg_prc_pkg::CRC_W-1:0]   crc_next
);

   logic [ogg_prc_pkg::CRC_W-1:0] running_ff;
   logic [ogg_prc_pkg::CRC_W-1:0] running_in;

   // msb-first byte update, no reflection, no final xor
   function automatic logic [ogg_prc_pkg::CRC_W-1:0] crc_byte(
      input logic [ogg_prc_pkg::CRC_W-1:0] crc_start,
      input logic [7:0]                    data
   );
      logic [ogg_prc_pkg::CRC_W-1:0] crc;
      crc = crc_start ^ {data, 24'h000000};
      for (int i = 0; i < 8; i++) begin
         if (crc[ogg_prc_pkg::CRC_W-1]) begin
            crc = {crc[ogg_prc_pkg::CRC_W-2:0], 1'b0} ^ ogg_prc_pkg::CRC_POLY;
         end else begin
            crc = {crc[ogg_prc_pkg::CRC_W-2:0], 1'b0};
         end
      end
      return crc;
   endfunction

   always_comb begin
      crc_next   = crc_byte(ctl.restart ? '0 : running_ff, ctl.data);
      running_in = ctl.update ? crc_next : running_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
      end else begin
         running_ff <= running_in;
      end
   end

endmodule
